// ===== hdl/dmsh_pkg.sv =====
`default_nettype none

package dmsh_pkg;

    localparam int unsigned HashWidth  = 30;
    localparam int unsigned PackShift  = 31;
    localparam int unsigned OutWidth   = 61;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ProdWidth  = HashWidth + CharWidth;
    localparam int unsigned FoldDepth  = 2 ** (ProdWidth - HashWidth);
    localparam int unsigned TdataWidth = ((2 * OutWidth + 7) / 8) * 8;

    localparam logic [HashWidth-1:0] ModA  = 30'd1000000009;
    localparam logic [HashWidth-1:0] ModB  = 30'd1000000007;
    localparam logic [HashWidth-1:0] BaseA = 30'd43;
    localparam logic [HashWidth-1:0] BaseB = 30'd37;

    typedef logic [HashWidth-1:0] hash_t;
    typedef hash_t fold_tab_t [FoldDepth];

    typedef struct packed {
        logic [CharWidth-1:0] char_byte;
        logic                 is_last;
    } item_t;

    // entry i holds (i * 2^30) mod m, built by repeated addition
    function automatic fold_tab_t fold_build(input hash_t m);
        fold_tab_t            tab;
        logic [HashWidth:0]   step;
        logic [HashWidth:0]   acc;
        step = (31'd1 << HashWidth) - {1'b0, m};
        acc  = '0;
        for (int i = 0; i < int'(FoldDepth); i++) begin
            tab[i] = acc[HashWidth-1:0];
            acc    = acc + step;
            if (acc >= {1'b0, m}) begin
                acc = acc - {1'b0, m};
            end
        end
        return tab;
    endfunction

    function automatic logic [OutWidth-1:0] pack_pair(input hash_t ha, input hash_t hb);
        return {ha, 1'b0, hb};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dmsh_lane.sv =====
`default_nettype none

module dmsh_lane #(
    parameter dmsh_pkg::hash_t MODULUS = dmsh_pkg::ModA,
    parameter dmsh_pkg::hash_t BASE    = dmsh_pkg::BaseA
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire dmsh_pkg::item_t item,
    output dmsh_pkg::hash_t      fwd_hash,
    output dmsh_pkg::hash_t      bwd_hash
);

    localparam int unsigned HW = dmsh_pkg::HashWidth;
    localparam int unsigned PW = dmsh_pkg::ProdWidth;
    localparam dmsh_pkg::fold_tab_t FOLD = dmsh_pkg::fold_build(MODULUS);

    dmsh_pkg::hash_t fwd_reg, fwd_next;
    dmsh_pkg::hash_t bwd_reg, bwd_next;
    dmsh_pkg::hash_t pow_reg, pow_next;

    // x < 2^38: fold the high byte through the table, then one subtract
    function automatic dmsh_pkg::hash_t fold(input logic [PW-1:0] x);
        dmsh_pkg::hash_t lo;
        logic [HW:0]     s;
        lo = x[HW-1:0];
        if (lo >= MODULUS) begin
            lo = lo - MODULUS;
        end
        s = {1'b0, FOLD[x[PW-1:HW]]} + {1'b0, lo};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[HW-1:0];
    endfunction

    logic [PW-1:0] fwd_sum;
    logic [PW-1:0] pow_prod;
    logic [PW-1:0] bwd_sum;

    always_comb begin
        fwd_sum  = PW'(fwd_reg) + PW'(pow_reg) * PW'(item.char_byte);
        pow_prod = PW'(pow_reg) * PW'(BASE);
        bwd_sum  = PW'(bwd_reg) * PW'(BASE) + PW'(item.char_byte);
        fwd_next = fold(fwd_sum);
        pow_next = fold(pow_prod);
        bwd_next = fold(bwd_sum);
    end

    assign fwd_hash = fwd_next;
    assign bwd_hash = bwd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= '0;
            bwd_reg <= '0;
            pow_reg <= HW'(1);
        end else if (step_en) begin
            if (item.is_last) begin
                fwd_reg <= '0;
                bwd_reg <= '0;
                pow_reg <= HW'(1);
            end else begin
                fwd_reg <= fwd_next;
                bwd_reg <= bwd_next;
                pow_reg <= pow_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dual_modulus_string_hash_unit.sv =====
`default_nettype none

// Channel  | Ports          | Word contents (lowest bit up)
// input    | s_axis_t*      | tdata: char_byte[7:0]; tlast: is_last
// result   | m_axis_t*      | tdata: forward_hash[60:0], backward_hash[121:61], zero pad
//
// One word per cycle unless a held result stalls a last byte: a byte waits in the
// input register, then both modulus lanes update their sums and running powers.
// A result word is loaded into the output register at the same edge its last
// byte leaves the input register. aresetn (synchronous) clears all sums to zero
// and powers to one. A held result stalls only a last byte; other bytes keep flowing.

module dual_modulus_string_hash_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // char_byte
    input  wire logic                            s_axis_tlast,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [dmsh_pkg::TdataWidth-1:0] m_axis_tdata   // forward_hash, backward_hash
);

    localparam int unsigned OW = dmsh_pkg::OutWidth;

    logic            in_valid_reg, in_valid_next;
    dmsh_pkg::item_t in_item_reg;
    logic            out_valid_reg, out_valid_next;
    logic [OW-1:0]   fwd_out_reg, bwd_out_reg;

    logic            advance;
    logic            out_load;
    dmsh_pkg::hash_t fwd_a, bwd_a, fwd_b, bwd_b;

    assign advance       = in_valid_reg
                         && (!in_item_reg.is_last || !out_valid_reg || m_axis_tready);
    assign out_load      = advance && in_item_reg.is_last;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.char_byte <= s_axis_tdata;
            in_item_reg.is_last   <= s_axis_tlast;
        end
        if (out_load) begin
            fwd_out_reg <= dmsh_pkg::pack_pair(fwd_a, fwd_b);
            bwd_out_reg <= dmsh_pkg::pack_pair(bwd_a, bwd_b);
        end
    end

    dmsh_lane #(
        .MODULUS (dmsh_pkg::ModA),
        .BASE    (dmsh_pkg::BaseA)
    ) u_lane_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_item_reg),
        .fwd_hash (fwd_a),
        .bwd_hash (bwd_a)
    );

    dmsh_lane #(
        .MODULUS (dmsh_pkg::ModB),
        .BASE    (dmsh_pkg::BaseB)
    ) u_lane_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_item_reg),
        .fwd_hash (fwd_b),
        .bwd_hash (bwd_b)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(dmsh_pkg::TdataWidth - 2 * OW)'(0), bwd_out_reg, fwd_out_reg};

    // a held byte that cannot advance stays in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input register lost a held byte");

    // a last byte never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !out_valid_reg || m_axis_tready)
        else $error("result overwritten before it was taken");

    // every reduced residue stays below its modulus, and the pack gap stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[30] && !m_axis_tdata[91]
            && m_axis_tdata[60:31] < dmsh_pkg::ModA && m_axis_tdata[29:0] < dmsh_pkg::ModB
            && m_axis_tdata[121:92] < dmsh_pkg::ModA && m_axis_tdata[90:61] < dmsh_pkg::ModB)
        else $error("hash residue out of range");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned HoldAfter  = 300;
    localparam int unsigned ByteTarget = 900;

    typedef bit [63:0] wide_t;

    typedef struct packed {
        bit [dmsh_pkg::OutWidth-1:0] bwd;
        bit [dmsh_pkg::OutWidth-1:0] fwd;
    } digest_t;

    class hash_tracker;
        wide_t   fwd_a, fwd_b, bwd_a, bwd_b, pow_a, pow_b;
        wide_t   mod_a  = wide_t'(dmsh_pkg::ModA);
        wide_t   mod_b  = wide_t'(dmsh_pkg::ModB);
        wide_t   base_a = wide_t'(dmsh_pkg::BaseA);
        wide_t   base_b = wide_t'(dmsh_pkg::BaseB);
        digest_t pending_digests[$];
        int      errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            fwd_a = 0;
            fwd_b = 0;
            bwd_a = 0;
            bwd_b = 0;
            pow_a = 1;
            pow_b = 1;
        endfunction

        function void absorb_byte(input logic [7:0] ch, input logic last);
            wide_t   c;
            digest_t d;
            c     = wide_t'(ch);
            fwd_a = (fwd_a + (pow_a * c) % mod_a) % mod_a;
            fwd_b = (fwd_b + (pow_b * c) % mod_b) % mod_b;
            pow_a = (pow_a * base_a) % mod_a;
            pow_b = (pow_b * base_b) % mod_b;
            bwd_a = (bwd_a * base_a + c) % mod_a;
            bwd_b = (bwd_b * base_b + c) % mod_b;
            if (last) begin
                d.fwd = dmsh_pkg::OutWidth'((fwd_a << dmsh_pkg::PackShift) | fwd_b);
                d.bwd = dmsh_pkg::OutWidth'((bwd_a << dmsh_pkg::PackShift) | bwd_b);
                pending_digests.push_back(d);
                restart();
            end
        endfunction

        function void match_digest(input logic [dmsh_pkg::TdataWidth-1:0] word);
            digest_t exp_d;
            if (pending_digests.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h", $time, word);
                errors++;
                return;
            end
            exp_d = pending_digests.pop_front();
            if (word[dmsh_pkg::OutWidth-1:0] !== exp_d.fwd) begin
                $display("%0t: forward hash expected %h, got %h",
                         $time, exp_d.fwd, word[dmsh_pkg::OutWidth-1:0]);
                errors++;
            end
            if (word[2*dmsh_pkg::OutWidth-1:dmsh_pkg::OutWidth] !== exp_d.bwd) begin
                $display("%0t: backward hash expected %h, got %h",
                         $time, exp_d.bwd, word[2*dmsh_pkg::OutWidth-1:dmsh_pkg::OutWidth]);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_digests.size();
        endfunction
    endclass

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dmsh_pkg::TdataWidth-1:0] m_axis_tdata;

    hash_tracker tracker = new();
    int          words_in     = 0;
    int          bytes_queued = 0;
    int          burst_left   = 0;
    int unsigned cycles       = 0;

    dual_modulus_string_hash_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            tracker.absorb_byte(s_axis_tdata, s_axis_tlast);
            words_in <= words_in + 1;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tracker.match_digest(m_axis_tdata);
        end
    end

    // receiver: segments of differing stall density, plus one long hold-off
    initial begin
        bit hold_done;
        int seg_left;
        int mode;
        hold_done = 1'b0;
        seg_left  = 0;
        mode      = 0;
        forever begin
            @(posedge aclk);
            if (!hold_done && words_in >= HoldAfter) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        bytes_queued++;
    endtask

    // fill: 0 random, 1 all ones, 2 all zeros, 3 alternating 55/aa
    task automatic send_string(input int len, input int fill);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            case (fill)
                1: ch = 8'hff;
                2: ch = 8'h00;
                3: ch = i[0] ? 8'haa : 8'h55;
                default: ch = 8'($urandom_range(0, 255));
            endcase
            send_byte(ch, i == len - 1);
        end
    endtask

    initial begin
        int len;
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h80, 1'b1);
        send_string(8, 1);
        send_string(6, 2);
        send_string(4, 3);

        while (bytes_queued < ByteTarget) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                len = $urandom_range(1, 8);
            end else if (pick < 95) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(100, 200);
            end
            send_string(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge aclk); while (tracker.outstanding() != 0);
        repeat (8) @(posedge aclk);

        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
